[hw/rtl/trlr_pkg.sv]
// Shared types and constants for the tandem repeat longest-run counter.
package trlr_pkg;

  localparam int NUM_PATTERNS = 3;
  localparam int BASE_W       = 2;
  localparam int PAT_W        = 16;
  localparam int LEN_W        = 4;
  localparam int OUT_W        = 16;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = 4'd4;
  localparam logic [OUT_W-1:0] OUT_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_PATTERN_A = 3'd0,
    REG_LENGTH_A  = 3'd1,
    REG_PATTERN_B = 3'd2,
    REG_LENGTH_B  = 3'd3,
    REG_PATTERN_C = 3'd4,
    REG_LENGTH_C  = 3'd5
  } trlr_reg_t;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] length;
  } trlr_pat_cfg_t;

  typedef struct packed {
    logic step;
    logic clear;
  } trlr_ctl_t;

endpackage

[hw/rtl/trlr_cfg.sv]
// Configuration register file with an APB-style write and read port.
module trlr_cfg
  import trlr_pkg::*;
(
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]                cfg_paddr,
  input  logic [CFG_DATA_W-1:0]                cfg_pwdata,
  output logic [CFG_DATA_W-1:0]                cfg_prdata,
  output logic                                 cfg_pready,
  output trlr_pat_cfg_t [NUM_PATTERNS-1:0]     pat_cfg
);

  trlr_pat_cfg_t [NUM_PATTERNS-1:0] cfg_r;
  trlr_pat_cfg_t [NUM_PATTERNS-1:0] cfg_nxt;
  logic                             wr_en;
  trlr_reg_t                        reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = trlr_reg_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign pat_cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PATTERN_A: cfg_nxt[0].pattern = cfg_pwdata[PAT_W-1:0];
        REG_LENGTH_A:  cfg_nxt[0].length  = cfg_pwdata[LEN_W-1:0];
        REG_PATTERN_B: cfg_nxt[1].pattern = cfg_pwdata[PAT_W-1:0];
        REG_LENGTH_B:  cfg_nxt[1].length  = cfg_pwdata[LEN_W-1:0];
        REG_PATTERN_C: cfg_nxt[2].pattern = cfg_pwdata[PAT_W-1:0];
        REG_LENGTH_C:  cfg_nxt[2].length  = cfg_pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_A: cfg_prdata = CFG_DATA_W'(cfg_r[0].pattern);
      REG_LENGTH_A:  cfg_prdata = CFG_DATA_W'(cfg_r[0].length);
      REG_PATTERN_B: cfg_prdata = CFG_DATA_W'(cfg_r[1].pattern);
      REG_LENGTH_B:  cfg_prdata = CFG_DATA_W'(cfg_r[1].length);
      REG_PATTERN_C: cfg_prdata = CFG_DATA_W'(cfg_r[2].pattern);
      REG_LENGTH_C:  cfg_prdata = CFG_DATA_W'(cfg_r[2].length);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        cfg_r[p].pattern <= '0;
        cfg_r[p].length  <= LEN_RESET;
      end
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hw/rtl/trlr_unit.sv]
// Per-pattern match, phase tracking, run counters and running maximum.
module trlr_unit
  import trlr_pkg::*;
#(
  parameter int MAX_PATTERN_LEN = 8,
  parameter int COUNT_BITS      = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  trlr_pat_cfg_t                                 pat_cfg,
  input  logic [MAX_PATTERN_LEN-1:0][BASE_W-1:0]        hist,
  input  logic [$clog2(MAX_PATTERN_LEN+1)-1:0]          seen,
  input  trlr_ctl_t                                     ctl,
  output logic [COUNT_BITS-1:0]                         best_upd
);

  localparam int LEN_EW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int PH_W   = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

  logic [MAX_PATTERN_LEN-1:0][COUNT_BITS-1:0] runs_r;
  logic [COUNT_BITS-1:0]                      best_r;
  logic [PH_W-1:0]                            phase_r;
  logic [PH_W-1:0]                            phase_nxt;
  logic [LEN_EW-1:0]                          len_eff;
  logic [PH_W-1:0]                            ph;
  logic [LEN_EW-1:0]                          ph_inc;
  logic                                       match;
  logic [COUNT_BITS-1:0]                      cur_run;
  logic [COUNT_BITS-1:0]                      new_run;

  always_comb begin
    if (pat_cfg.length == '0) begin
      len_eff = LEN_EW'(1);
    end else if (32'(pat_cfg.length) > 32'(MAX_PATTERN_LEN)) begin
      len_eff = LEN_EW'(MAX_PATTERN_LEN);
    end else begin
      len_eff = LEN_EW'(pat_cfg.length);
    end
  end

  // The newest base sits in hist[0]; pattern base 0 is the oldest of the match.
  always_comb begin
    logic [LEN_EW-1:0] pos;
    logic [BASE_W-1:0] want;
    match = (seen >= len_eff);
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      pos  = LEN_EW'(len_eff - LEN_EW'(1) - LEN_EW'(j));
      want = BASE_W'(pat_cfg.pattern >> (BASE_W * j));
      if (LEN_EW'(j) < len_eff) begin
        if (hist[pos[PH_W-1:0]] != want) begin
          match = 1'b0;
        end
      end
    end
  end

  always_comb begin
    ph        = (LEN_EW'(phase_r) >= len_eff) ? '0 : phase_r;
    ph_inc    = LEN_EW'(ph) + LEN_EW'(1);
    phase_nxt = (ph_inc >= len_eff) ? '0 : ph_inc[PH_W-1:0];
    cur_run   = runs_r[ph];
    if (!match) begin
      new_run = '0;
    end else if (cur_run == '1) begin
      new_run = cur_run;
    end else begin
      new_run = cur_run + COUNT_BITS'(1);
    end
    best_upd = (new_run > best_r) ? new_run : best_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      runs_r  <= '0;
      best_r  <= '0;
      phase_r <= '0;
    end else if (ctl.step) begin
      if (ctl.clear) begin
        runs_r  <= '0;
        best_r  <= '0;
        phase_r <= '0;
      end else begin
        runs_r[ph] <= new_run;
        best_r     <= best_upd;
        phase_r    <= phase_nxt;
      end
    end
  end

endmodule

[hw/rtl/tandem_repeat_longest_run.sv]
// Top level of the tandem repeat longest-run counter: stream ports, base history and result.
// The block takes one base per clock cycle, unless stalled, into an input register and
// processes it: the base joins a shift history; for each of three patterns a unit compares
// the latest bases with the pattern, updates the run counter of the current phase and keeps
// the longest run. The word marked with in_tlast produces one result word holding the three
// maxima, then clears all sequence state; patterns and lengths stay. The result waits in an
// output register, and further bases keep flowing while it waits; only a second final base
// stalls until the previous result is taken. There is no clearing pass after reset.
module tandem_repeat_longest_run
  import trlr_pkg::*;
#(
  parameter int MAX_PATTERN_LEN = 8,
  parameter int COUNT_BITS      = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,      // [1:0] base
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [3*OUT_W-1:0]        out_tdata,     // [15:0] longest_a, [31:16] longest_b,
                                                   // [47:32] longest_c
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [CFG_DATA_W-1:0]     cfg_prdata,
  output logic                      cfg_pready
);

  localparam int SEEN_W = $clog2(MAX_PATTERN_LEN + 1);
  localparam int SAT_W  = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

  trlr_pat_cfg_t [NUM_PATTERNS-1:0]               pat_cfg;
  logic                                           in_valid_r;
  logic                                           in_valid_nxt;
  logic [BASE_W-1:0]                              in_base_r;
  logic                                           in_last_r;
  logic                                           in_accept;
  logic                                           out_free;
  logic                                           consume;
  logic                                           out_valid_r;
  logic                                           out_valid_nxt;
  logic [3*OUT_W-1:0]                             out_data_r;
  logic [3*OUT_W-1:0]                             out_data_nxt;
  logic [MAX_PATTERN_LEN-1:0][BASE_W-1:0]         hist_r;
  logic [MAX_PATTERN_LEN-1:0][BASE_W-1:0]         hist_nxt;
  logic [SEEN_W-1:0]                              seen_r;
  logic [SEEN_W-1:0]                              seen_nxt;
  logic [NUM_PATTERNS-1:0][COUNT_BITS-1:0]        best_upd;
  trlr_ctl_t                                      ctl;

  trlr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .pat_cfg     (pat_cfg)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign consume   = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || consume;
  assign in_accept = in_tvalid && in_tready;
  assign ctl       = '{step: consume, clear: in_last_r};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    hist_nxt[0] = in_base_r;
    for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
      hist_nxt[k] = hist_r[k-1];
    end
    seen_nxt = (32'(seen_r) < 32'(MAX_PATTERN_LEN)) ? seen_r + SEEN_W'(1) : seen_r;
  end

  for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_unit
    trlr_unit #(
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
      .COUNT_BITS      (COUNT_BITS)
    ) u_unit (
      .clk      (clk),
      .rst_n    (rst_n),
      .pat_cfg  (pat_cfg[p]),
      .hist     (hist_nxt),
      .seen     (seen_nxt),
      .ctl      (ctl),
      .best_upd (best_upd[p])
    );
  end

  always_comb begin
    logic [SAT_W-1:0] wide;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      wide = SAT_W'(best_upd[p]);
      out_data_nxt[p*OUT_W +: OUT_W] = (wide > SAT_W'(OUT_MAX)) ? OUT_MAX : wide[OUT_W-1:0];
    end
  end

  always_comb begin
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (consume) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
    if (consume && in_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hist_r      <= '0;
      seen_r      <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (consume) begin
        if (in_last_r) begin
          hist_r <= '0;
          seen_r <= '0;
        end else begin
          hist_r <= hist_nxt;
          seen_r <= seen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_base_r <= in_tdata[BASE_W-1:0];
      in_last_r <= in_tlast;
    end
    if (consume && in_last_r) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    consume && in_last_r |=> out_tvalid)
    else $error("final base processed without a result word");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    consume && in_last_r |=> (seen_r == '0) && (hist_r == '0))
    else $error("sequence state not cleared after final base");

  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(seen_r) <= 32'(MAX_PATTERN_LEN))
    else $error("base count exceeds history depth");
`endif

endmodule
